/* hw/rtl/button_long_press_multi_click_defines.svh */
// assertion macros for the button long-press / multi-click block
// each macro expects clk and rst_n in the scope where it is used
`ifndef BUTTON_LONG_PRESS_MULTI_CLICK_DEFINES_SVH
`define BUTTON_LONG_PRESS_MULTI_CLICK_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BLPMC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blpmc same-cycle check failed");

// next-cycle implication, disabled during reset
`define BLPMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blpmc next-cycle check failed");

`endif

/* hw/rtl/blpmc_pkg.sv */
`timescale 1ns / 1ps

package blpmc_pkg;

  // timestamp arithmetic width, differences wrap modulo 2**TIME_W
  localparam int unsigned TIME_W = 32;
  // config address width: four 32-bit registers
  localparam int unsigned CFG_AW = 4;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [15:0]       dur_t;
  typedef logic [3:0]        cnt_t;

  // register reset values
  localparam dur_t DEBOUNCE_RST   = 16'd50;
  localparam dur_t LONG_PRESS_RST = 16'd5000;
  localparam dur_t CLICK_WIN_RST  = 16'd1500;
  localparam cnt_t CLICKS_REQ_RST = 4'd3;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_CLICK_WIN  = 2'd2,
    REG_CLICKS_REQ = 2'd3
  } reg_idx_t;

endpackage

/* hw/rtl/blpmc_in_if.sv */
`timescale 1ns / 1ps

interface blpmc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        raw_pressed;

  modport source (output valid, output now_ms, output raw_pressed, input ready);
  modport sink (input valid, input now_ms, input raw_pressed, output ready);
endinterface

/* hw/rtl/blpmc_out_if.sv */
`timescale 1ns / 1ps

interface blpmc_out_if;
  logic       valid;
  logic       ready;
  logic       long_press_pulse;
  logic       multi_click_pulse;
  logic       debounced_level;
  logic [3:0] clicks_so_far;

  modport source (
    output valid, output long_press_pulse, output multi_click_pulse,
    output debounced_level, output clicks_so_far, input ready
  );
  modport sink (
    input valid, input long_press_pulse, input multi_click_pulse,
    input debounced_level, input clicks_so_far, output ready
  );
endinterface

/* hw/rtl/button_long_press_multi_click.sv */
`timescale 1ns / 1ps

// channel  | dir | beat contents
// ---------+-----+-----------------------------------------------------------
// in_if    | in  | now_ms, raw_pressed
// out_if   | out | long_press_pulse, multi_click_pulse, debounced_level,
//          |     | clicks_so_far
// apb      | in  | psel/penable/pwrite/paddr/pwdata; out: prdata/pready
//
// one input beat per clock unless the output stalls; its result beat is registered
// and shows in the cycle after acceptance.
// the per-sample update is one short combinational pass over the state regs
// in_ready drops only while a result is held and out_ready is low.
// rst_n is synchronous: state clears to released at time zero, registers load
// their defaults, the output register empties.

module button_long_press_multi_click (
  input  logic                         clk,
  input  logic                         rst_n,
  blpmc_in_if.sink                     in_if,
  blpmc_out_if.source                  out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [blpmc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // configuration registers
  blpmc_pkg::dur_t debounce_r;
  blpmc_pkg::dur_t long_press_r;
  blpmc_pkg::dur_t click_win_r;
  blpmc_pkg::cnt_t clicks_req_r;

  // sample state
  logic             last_raw_r, last_raw_nxt;
  logic             stable_r, stable_nxt;
  logic             press_r, press_nxt;
  logic             lp_done_r, lp_done_nxt;
  blpmc_pkg::cnt_t  tally_r, tally_nxt;
  blpmc_pkg::time_t last_chg_r, last_chg_nxt;
  blpmc_pkg::time_t press_start_r, press_start_nxt;
  blpmc_pkg::time_t win_start_r, win_start_nxt;

  // result register
  logic            out_valid_r;
  logic            long_p_r, multi_p_r, level_r;
  blpmc_pkg::cnt_t clicks_r;

  logic             long_p, multi_p;
  logic             in_acc;
  logic             cfg_wr;
  blpmc_pkg::reg_idx_t cfg_idx;
  blpmc_pkg::time_t now;
  blpmc_pkg::time_t el_db, el_press, el_win, el_press_n, el_win_n;

  // handshake
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  // apb register file
  assign pready  = 1'b1;
  assign cfg_idx = blpmc_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= blpmc_pkg::DEBOUNCE_RST;
      long_press_r <= blpmc_pkg::LONG_PRESS_RST;
      click_win_r  <= blpmc_pkg::CLICK_WIN_RST;
      clicks_req_r <= blpmc_pkg::CLICKS_REQ_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        blpmc_pkg::REG_DEBOUNCE:   debounce_r   <= pwdata[15:0];
        blpmc_pkg::REG_LONG_PRESS: long_press_r <= pwdata[15:0];
        blpmc_pkg::REG_CLICK_WIN:  click_win_r  <= pwdata[15:0];
        blpmc_pkg::REG_CLICKS_REQ: clicks_req_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      blpmc_pkg::REG_DEBOUNCE:   prdata = {16'd0, debounce_r};
      blpmc_pkg::REG_LONG_PRESS: prdata = {16'd0, long_press_r};
      blpmc_pkg::REG_CLICK_WIN:  prdata = {16'd0, click_win_r};
      blpmc_pkg::REG_CLICKS_REQ: prdata = {28'd0, clicks_req_r};
      default:                   prdata = 32'd0;
    endcase
  end

  // per-sample update: debounce, press tracking, click counting, long press
  always_comb begin
    now             = blpmc_pkg::time_t'(in_if.now_ms);
    last_raw_nxt    = last_raw_r;
    stable_nxt      = stable_r;
    press_nxt       = press_r;
    lp_done_nxt     = lp_done_r;
    tally_nxt       = tally_r;
    last_chg_nxt    = last_chg_r;
    press_start_nxt = press_start_r;
    win_start_nxt   = win_start_r;
    long_p          = 1'b0;
    multi_p         = 1'b0;

    // raw level change restarts the debounce time
    if (in_if.raw_pressed != last_raw_r) begin
      last_raw_nxt = in_if.raw_pressed;
      last_chg_nxt = now;
    end

    el_db    = now - last_chg_nxt;
    el_press = now - press_start_r;
    el_win   = now - win_start_r;

    // level held long enough becomes the debounced state
    if (el_db >= blpmc_pkg::time_t'(debounce_r) && in_if.raw_pressed != stable_r) begin
      stable_nxt = in_if.raw_pressed;
      if (in_if.raw_pressed) begin
        press_nxt       = 1'b1;
        lp_done_nxt     = 1'b0;
        press_start_nxt = now;
      end else if (press_r) begin
        // short press released: count a click
        if (!lp_done_r && el_press < blpmc_pkg::time_t'(long_press_r)) begin
          if (tally_r == 4'd0 || el_win > blpmc_pkg::time_t'(click_win_r)) begin
            tally_nxt     = 4'd1;
            win_start_nxt = now;
          end else begin
            tally_nxt = tally_r + 4'd1;
          end
          if (tally_nxt >= clicks_req_r) begin
            tally_nxt = 4'd0;
            multi_p   = 1'b1;
          end
        end
        press_nxt   = 1'b0;
        lp_done_nxt = 1'b0;
      end
    end

    el_press_n = now - press_start_nxt;
    el_win_n   = now - win_start_nxt;

    // held press reaches long-press time
    if (stable_nxt && press_nxt && !lp_done_nxt &&
        el_press_n >= blpmc_pkg::time_t'(long_press_r)) begin
      long_p      = 1'b1;
      lp_done_nxt = 1'b1;
      tally_nxt   = 4'd0;
    end

    // click window expired
    if (tally_nxt != 4'd0 && el_win_n > blpmc_pkg::time_t'(click_win_r)) begin
      tally_nxt = 4'd0;
    end
  end

  // state update on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b0;
      stable_r      <= 1'b0;
      press_r       <= 1'b0;
      lp_done_r     <= 1'b0;
      tally_r       <= '0;
      last_chg_r    <= '0;
      press_start_r <= '0;
      win_start_r   <= '0;
    end else if (in_acc) begin
      last_raw_r    <= last_raw_nxt;
      stable_r      <= stable_nxt;
      press_r       <= press_nxt;
      lp_done_r     <= lp_done_nxt;
      tally_r       <= tally_nxt;
      last_chg_r    <= last_chg_nxt;
      press_start_r <= press_start_nxt;
      win_start_r   <= win_start_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      long_p_r  <= long_p;
      multi_p_r <= multi_p;
      level_r   <= stable_nxt;
      clicks_r  <= tally_nxt;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.long_press_pulse  = long_p_r;
  assign out_if.multi_click_pulse = multi_p_r;
  assign out_if.debounced_level   = level_r;
  assign out_if.clicks_so_far     = clicks_r;

endmodule

/* hw/rtl/blpmc_chk.sv */
`timescale 1ns / 1ps
`include "button_long_press_multi_click_defines.svh"

module blpmc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       long_press_pulse,
  input logic       multi_click_pulse,
  input logic       debounced_level,
  input logic [3:0] clicks_so_far
);

  logic       stalled;
  logic [6:0] beat;
  logic       multi_ok;
  logic       long_ok;

  assign stalled  = out_valid && !out_ready;
  assign beat     = {long_press_pulse, multi_click_pulse, debounced_level, clicks_so_far};
  assign multi_ok = !debounced_level && clicks_so_far == 4'd0 && !long_press_pulse;
  assign long_ok  = debounced_level && clicks_so_far == 4'd0;

  // held result stays put while stalled
  `BLPMC_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(beat))

  // an accepted beat always produces a result next cycle
  `BLPMC_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, out_valid)

  // input is open whenever the output register is empty
  `BLPMC_ASSERT_SAME(a_ready_empty, !out_valid, in_ready)

  // multi-click fires on release and clears the tally
  `BLPMC_ASSERT_SAME(a_multi_release, out_valid && multi_click_pulse, multi_ok)

  // long press reports while pressed with no clicks pending
  `BLPMC_ASSERT_SAME(a_long_pressed, out_valid && long_press_pulse, long_ok)

endmodule

bind button_long_press_multi_click blpmc_chk u_blpmc_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .long_press_pulse  (out_if.long_press_pulse),
  .multi_click_pulse (out_if.multi_click_pulse),
  .debounced_level   (out_if.debounced_level),
  .clicks_so_far     (out_if.clicks_so_far)
);
